// ===== sv/assert_macros.svh =====
// Shared assertion macros for the shader checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, muted while reset is asserted.
`define VES_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on clk, muted while reset is asserted.
`define VES_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

// ===== sv/ves_pkg.sv =====
package ves_pkg;

	// Beat commands
	typedef enum logic [1:0] {
		CMD_SEED    = 2'd0,
		CMD_PALETTE = 2'd1,
		CMD_PIXEL   = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	// Input beat: a table load or a pixel to shade
	typedef struct packed {
		logic [1:0] command;
		logic [3:0] cell_index;
		logic [9:0] x_coord;
		logic [9:0] y_coord;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} in_beat_t;

	// Result beat: one shaded pixel
	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic [3:0] nearest_cell;
	} out_beat_t;

	// Edge darkening: gap below EDGE_LIMIT scales by floor(gap*255/400),
	// done as (gap * SCALE_MUL) >> SCALE_SHIFT, exact for gap < 400.
	localparam int EDGE_LIMIT  = 400;
	localparam int GAP_BITS    = 9;
	localparam int SCALE_MUL   = 42782115;
	localparam int SCALE_SHIFT = 26;
	localparam int MUL_BITS    = GAP_BITS + SCALE_SHIFT;

endpackage

// ===== sv/ves_cell.sv =====
module ves_cell import ves_pkg::*; #(
	parameter int CELL_COUNT = 14,
	parameter int COORD_BITS = 10,
	parameter int INDEX      = 0,
	localparam int DIST_W    = 2 * COORD_BITS + 1,
	localparam int NEAR_W    = $clog2(CELL_COUNT)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              valid,
	input  in_beat_t          beat,
	input  logic [DIST_W-1:0] d1,
	input  logic [DIST_W-1:0] d2,
	input  logic [NEAR_W-1:0] nearest,
	output logic              valid_s1,
	output in_beat_t          beat_s1,
	output logic [DIST_W-1:0] d1_s1,
	output logic [DIST_W-1:0] d2_s1,
	output logic [NEAR_W-1:0] nearest_s1
);

	logic [COORD_BITS-1:0]   seed_col_q;
	logic [COORD_BITS-1:0]   seed_row_q;
	logic [COORD_BITS-1:0]   px;
	logic [COORD_BITS-1:0]   py;
	logic [COORD_BITS-1:0]   dx;
	logic [COORD_BITS-1:0]   dy;
	logic [2*COORD_BITS-1:0] sq_x;
	logic [2*COORD_BITS-1:0] sq_y;
	logic [DIST_W-1:0]       sq_dist;
	logic [DIST_W-1:0]       d1_nxt;
	logic [DIST_W-1:0]       d2_nxt;
	logic [NEAR_W-1:0]       near_nxt;
	logic                    seed_we;

	// Squared distance from the passing pixel to this cell's seed
	assign px      = COORD_BITS'(beat.x_coord);
	assign py      = COORD_BITS'(beat.y_coord);
	assign dx      = (px >= seed_col_q) ? px - seed_col_q : seed_col_q - px;
	assign dy      = (py >= seed_row_q) ? py - seed_row_q : seed_row_q - py;
	assign sq_x    = (2*COORD_BITS)'(dx) * (2*COORD_BITS)'(dx);
	assign sq_y    = (2*COORD_BITS)'(dy) * (2*COORD_BITS)'(dy);
	assign sq_dist = DIST_W'(sq_x) + DIST_W'(sq_y);

	// Insert into the best-two list; strict compares keep the lower index on ties
	always_comb begin
		d1_nxt   = d1;
		d2_nxt   = d2;
		near_nxt = nearest;
		priority if (sq_dist < d1) begin
			d2_nxt   = d1;
			d1_nxt   = sq_dist;
			near_nxt = NEAR_W'(INDEX);
		end else if (sq_dist < d2) begin
			d2_nxt = sq_dist;
		end
	end

	// Take a seed load addressed to this cell as it passes
	assign seed_we = advance && valid && (beat.command == CMD_SEED)
		&& (int'(beat.cell_index) == INDEX);

	always_ff @(posedge clk) begin
		if (seed_we) begin
			seed_col_q <= px;
			seed_row_q <= py;
		end
	end

	// Hand the beat to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			beat_s1    <= beat;
			d1_s1      <= d1_nxt;
			d2_s1      <= d2_nxt;
			nearest_s1 <= near_nxt;
		end
	end

endmodule

// ===== sv/ves_shade.sv =====
module ves_shade import ves_pkg::*; #(
	parameter int CELL_COUNT = 14,
	parameter int COORD_BITS = 10,
	localparam int DIST_W    = 2 * COORD_BITS + 1,
	localparam int NEAR_W    = $clog2(CELL_COUNT)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              valid,
	input  in_beat_t          beat,
	input  logic [DIST_W-1:0] d1,
	input  logic [DIST_W-1:0] d2,
	input  logic [NEAR_W-1:0] nearest,
	input  logic [NEAR_W-1:0] rotation,
	output logic              res_valid,
	output out_beat_t         res
);

	logic [23:0]         palette_q [CELL_COUNT];
	logic [NEAR_W:0]     sel_sum;
	logic [NEAR_W-1:0]   sel;
	logic                pal_we;

	logic                valid_s1;
	logic [23:0]         color_s1;
	logic [DIST_W-1:0]   gap_s1;
	logic [NEAR_W-1:0]   near_s1;

	logic [MUL_BITS-1:0] scale_prod;
	logic                valid_s2;
	logic                edge_s2;
	logic [7:0]          scale_s2;
	logic [23:0]         color_s2;
	logic [NEAR_W-1:0]   near_s2;

	logic [15:0]         red_prod;
	logic [15:0]         green_prod;
	logic [15:0]         blue_prod;

	// Store a palette load at the end of the chain, in beat order
	assign pal_we = advance && valid && (beat.command == CMD_PALETTE)
		&& (int'(beat.cell_index) < CELL_COUNT);

	always_ff @(posedge clk) begin
		if (pal_we) begin
			palette_q[NEAR_W'(beat.cell_index)] <= {beat.red_in, beat.green_in, beat.blue_in};
		end
	end

	// Rotate the nearest index; both terms are below the cell count
	assign sel_sum = (NEAR_W+1)'(nearest) + (NEAR_W+1)'(rotation);
	assign sel     = (sel_sum >= (NEAR_W+1)'(CELL_COUNT))
		? NEAR_W'(sel_sum - (NEAR_W+1)'(CELL_COUNT)) : NEAR_W'(sel_sum);

	// Stage 1: palette read and distance gap; drop load beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= valid && (beat.command == CMD_PIXEL);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			color_s1 <= palette_q[sel];
			gap_s1   <= d2 - d1;
			near_s1  <= nearest;
		end
	end

	// Stage 2: edge scale by reciprocal multiply
	assign scale_prod = MUL_BITS'(gap_s1[GAP_BITS-1:0]) * MUL_BITS'(SCALE_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			edge_s2  <= gap_s1 < DIST_W'(EDGE_LIMIT);
			scale_s2 <= scale_prod[SCALE_SHIFT +: 8];
			color_s2 <= color_s1;
			near_s2  <= near_s1;
		end
	end

	// Output stage: darken each channel near a cell edge, hold while stalled
	assign red_prod   = 16'(color_s2[23:16]) * 16'(scale_s2);
	assign green_prod = 16'(color_s2[15:8]) * 16'(scale_s2);
	assign blue_prod  = 16'(color_s2[7:0]) * 16'(scale_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (advance) begin
			res_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res.red_out      <= edge_s2 ? red_prod[15:8] : color_s2[23:16];
			res.green_out    <= edge_s2 ? green_prod[15:8] : color_s2[15:8];
			res.blue_out     <= edge_s2 ? blue_prod[15:8] : color_s2[7:0];
			res.nearest_cell <= 4'(near_s2);
		end
	end

endmodule

// ===== sv/voronoi_edge_shader.sv =====
// Throughput: one beat per cycle; every beat walks the chain of CELL_COUNT
// seed cells, one cell per cycle, then three shading stages.
// The whole chain stalls only while a result waits on res_ready.
// Reset clears all valid bits and rotation_q; seed and palette
// tables hold nothing defined until loaded.
module voronoi_edge_shader import ves_pkg::*; #(
	parameter int CELL_COUNT = 14,
	parameter int COORD_BITS = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      pix_valid,
	output logic      pix_ready,
	input  in_beat_t  pix,
	output logic      res_valid,
	input  logic      res_ready,
	output out_beat_t res,
	input  logic      cfg_we,
	input  logic [3:0] cfg_wdata
);

	localparam int DIST_W = 2 * COORD_BITS + 1;
	localparam int NEAR_W = $clog2(CELL_COUNT);

	logic              advance;
	logic [NEAR_W-1:0] rotation_q;

	logic              ch_valid   [CELL_COUNT+1];
	in_beat_t          ch_beat    [CELL_COUNT+1];
	logic [DIST_W-1:0] ch_d1      [CELL_COUNT+1];
	logic [DIST_W-1:0] ch_d2      [CELL_COUNT+1];
	logic [NEAR_W-1:0] ch_nearest [CELL_COUNT+1];

	// Reduce a rotation modulo the cell count by restoring subtraction
	function automatic logic [NEAR_W-1:0] rot_mod(input logic [3:0] v);
		logic [9:0] r;
		r = 10'(v);
		for (int k = 4; k >= 0; k--) begin
			if (r >= 10'(CELL_COUNT << k)) begin
				r = r - 10'(CELL_COUNT << k);
			end
		end
		return NEAR_W'(r);
	endfunction

	// Advance the whole chain unless a result is held
	assign advance   = !res_valid || res_ready;
	assign pix_ready = advance;

	// Rotation register, stored already reduced
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q <= '0;
		end else if (cfg_we) begin
			rotation_q <= rot_mod(cfg_wdata);
		end
	end

	// Feed the chain head with an empty best-two list
	assign ch_valid[0]   = pix_valid;
	assign ch_beat[0]    = pix;
	assign ch_d1[0]      = '1;
	assign ch_d2[0]      = '1;
	assign ch_nearest[0] = '0;

	for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
		ves_cell #(
			.CELL_COUNT(CELL_COUNT),
			.COORD_BITS(COORD_BITS),
			.INDEX     (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.valid     (ch_valid[i]),
			.beat      (ch_beat[i]),
			.d1        (ch_d1[i]),
			.d2        (ch_d2[i]),
			.nearest   (ch_nearest[i]),
			.valid_s1  (ch_valid[i+1]),
			.beat_s1   (ch_beat[i+1]),
			.d1_s1     (ch_d1[i+1]),
			.d2_s1     (ch_d2[i+1]),
			.nearest_s1(ch_nearest[i+1])
		);
	end

	// Palette lookup and edge darkening at the chain tail
	ves_shade #(
		.CELL_COUNT(CELL_COUNT),
		.COORD_BITS(COORD_BITS)
	) u_shade (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.valid    (ch_valid[CELL_COUNT]),
		.beat     (ch_beat[CELL_COUNT]),
		.d1       (ch_d1[CELL_COUNT]),
		.d2       (ch_d2[CELL_COUNT]),
		.nearest  (ch_nearest[CELL_COUNT]),
		.rotation (rotation_q),
		.res_valid(res_valid),
		.res      (res)
	);

endmodule

// ===== sv/ves_checker.sv =====
`include "assert_macros.svh"

module ves_checker import ves_pkg::*; #(
	parameter int CELL_COUNT = 14
) (
	input logic      clk,
	input logic      arst_n,
	input logic      pix_ready,
	input logic      res_valid,
	input logic      res_ready,
	input out_beat_t res
);

	// A held result keeps its payload
	`VES_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res))

	// A held result backs up the input side
	`VES_ASSERT_NOW(a_stall_blocks, res_valid && !res_ready, !pix_ready)

	// An empty output never refuses input
	`VES_ASSERT_NOW(a_empty_takes, !res_valid, pix_ready)

	// The reported nearest index names a real cell
	`VES_ASSERT_NOW(a_near_range, res_valid, int'(res.nearest_cell) < CELL_COUNT)

endmodule

bind voronoi_edge_shader ves_checker #(.CELL_COUNT(CELL_COUNT)) u_ves_checker (.*);
